// ===== sv/alm_pkg.sv =====
package alm_pkg;

  localparam int DATA_W      = 32;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int COUNT_W     = 6;
  localparam int MAX_RESULTS = 32;
  localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  // one result transaction handed from the sequencer to the output register
  typedef struct packed {
    logic                     valid;
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic [COUNT_W-1:0]       count;
  } res_t;

endpackage

// ===== sv/alm_nodes.sv =====
module alm_nodes #(
  parameter int  CAPACITY = 32,
  localparam int IW = $clog2(CAPACITY),
  localparam int LW = $clog2(CAPACITY) + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rd_en,
  input  logic [IW-1:0]                       rd_addr,
  output logic signed [alm_pkg::DATA_W-1:0]   rd_key,
  output logic signed [alm_pkg::DATA_W-1:0]   rd_value,
  output logic [LW-1:0]                       rd_next,
  output logic [LW-1:0]                       rd_prev,
  input  logic                                kv_we,
  input  logic [IW-1:0]                       kv_addr,
  input  logic signed [alm_pkg::DATA_W-1:0]   kv_key,
  input  logic signed [alm_pkg::DATA_W-1:0]   kv_value,
  input  logic                                next_we,
  input  logic [IW-1:0]                       next_addr,
  input  logic [LW-1:0]                       next_data,
  input  logic                                prev_we,
  input  logic [IW-1:0]                       prev_addr,
  input  logic [LW-1:0]                       prev_data
);
  import alm_pkg::*;

  localparam logic [LW-1:0] NIL = '1;

  logic signed [DATA_W-1:0] key_mem  [CAPACITY];
  logic signed [DATA_W-1:0] val_mem  [CAPACITY];
  logic [LW-1:0]            next_mem [CAPACITY];
  logic [LW-1:0]            prev_mem [CAPACITY];
  // link entries read as their initial chain until first written
  logic [CAPACITY-1:0]      next_ok;
  logic [CAPACITY-1:0]      prev_ok;

  logic [LW-1:0] next_raw;
  logic [LW-1:0] prev_raw;
  logic          next_ok_q;
  logic          prev_ok_q;
  logic [IW-1:0] addr_q;
  logic [LW-1:0] init_next;
  logic [LW-1:0] init_prev;

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[kv_addr] <= kv_key;
      val_mem[kv_addr] <= kv_value;
    end
    if (next_we) begin
      next_mem[next_addr] <= next_data;
    end
    if (prev_we) begin
      prev_mem[prev_addr] <= prev_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_ok <= '0;
      prev_ok <= '0;
    end else begin
      if (next_we) begin
        next_ok[next_addr] <= 1'b1;
      end
      if (prev_we) begin
        prev_ok[prev_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key    <= key_mem[rd_addr];
      rd_value  <= val_mem[rd_addr];
      next_raw  <= next_mem[rd_addr];
      prev_raw  <= prev_mem[rd_addr];
      next_ok_q <= next_ok[rd_addr];
      prev_ok_q <= prev_ok[rd_addr];
      addr_q    <= rd_addr;
    end
  end

  always_comb begin
    init_next = (addr_q == IW'(CAPACITY - 1)) ? NIL : ({1'b0, addr_q} + LW'(1));
    init_prev = (addr_q == '0) ? NIL : ({1'b0, addr_q} - LW'(1));
  end

  assign rd_next = next_ok_q ? next_raw : init_next;
  assign rd_prev = prev_ok_q ? prev_raw : init_prev;

endmodule

// ===== sv/alm_seq.sv =====
module alm_seq #(
  parameter int  CAPACITY = 32,
  localparam int IW = $clog2(CAPACITY),
  localparam int LW = $clog2(CAPACITY) + 1
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [alm_pkg::CMD_W-1:0]           in_cmd,
  input  logic signed [alm_pkg::DATA_W-1:0]   in_key,
  input  logic signed [alm_pkg::DATA_W-1:0]   in_value,
  output alm_pkg::res_t                       res,
  input  logic                                res_stall,
  output logic                                rd_en,
  output logic [IW-1:0]                       rd_addr,
  input  logic signed [alm_pkg::DATA_W-1:0]   rd_key,
  input  logic signed [alm_pkg::DATA_W-1:0]   rd_value,
  input  logic [LW-1:0]                       rd_next,
  input  logic [LW-1:0]                       rd_prev,
  output logic                                kv_we,
  output logic [IW-1:0]                       kv_addr,
  output logic signed [alm_pkg::DATA_W-1:0]   kv_key,
  output logic signed [alm_pkg::DATA_W-1:0]   kv_value,
  output logic                                next_we,
  output logic [IW-1:0]                       next_addr,
  output logic [LW-1:0]                       next_data,
  output logic                                prev_we,
  output logic [IW-1:0]                       prev_addr,
  output logic [LW-1:0]                       prev_data
);
  import alm_pkg::*;

  localparam int            CW  = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = '1;

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_ADD_WR    = 8'b0000_0010,
    S_ADD_LINK  = 8'b0000_0100,
    S_WALK      = 8'b0000_1000,
    S_RM_UNLINK = 8'b0001_0000,
    S_RM_FREE   = 8'b0010_0000,
    S_EMIT      = 8'b0100_0000,
    S_SR_NEXT   = 8'b1000_0000
  } state_t;

  function automatic logic is_slot(logic [LW-1:0] x);
    return x < LW'(CAPACITY);
  endfunction

  state_t                   state, state_next;
  logic [CMD_W-1:0]         op_cmd, op_cmd_next;
  logic signed [DATA_W-1:0] op_key, op_key_next;
  logic signed [DATA_W-1:0] op_value, op_value_next;
  logic [LW-1:0]            cur, cur_next;
  logic [LW-1:0]            prev_l, prev_l_next;
  logic [LW-1:0]            next_l, next_l_next;
  logic [CW-1:0]            steps, steps_next;
  logic [FOUND_W-1:0]       n_found, n_found_next;
  logic                     pend_valid, pend_valid_next;
  logic signed [DATA_W-1:0] pend_val, pend_val_next;
  logic [LW-1:0]            free_head, free_head_next;
  logic [LW-1:0]            list_head, list_head_next;
  logic [CW-1:0]            entry_count, entry_count_next;
  status_t                  r_status, r_status_next;
  logic signed [DATA_W-1:0] r_val, r_val_next;
  logic                     r_last, r_last_next;

  logic               accept;
  logic               hit;
  logic [FOUND_W-1:0] n_new;
  logic               steps_more;
  logic               walk_more;

  assign in_stall = rst || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // the shared compare unit: node just read against the held key, and also the held value for a remove
  always_comb begin
    if (op_cmd == CMD_REMOVE) begin
      hit = (rd_key == op_key) && (rd_value == op_value);
    end else begin
      hit = (rd_key == op_key);
    end
    n_new      = n_found + FOUND_W'(hit);
    steps_more = steps < CW'(CAPACITY);
    walk_more  = is_slot(rd_next) && steps_more && (n_new < FOUND_W'(MAX_RESULTS));
  end

  always_comb begin
    state_next       = state;
    op_cmd_next      = op_cmd;
    op_key_next      = op_key;
    op_value_next    = op_value;
    cur_next         = cur;
    prev_l_next      = prev_l;
    next_l_next      = next_l;
    steps_next       = steps;
    n_found_next     = n_found;
    pend_valid_next  = pend_valid;
    pend_val_next    = pend_val;
    free_head_next   = free_head;
    list_head_next   = list_head;
    entry_count_next = entry_count;
    r_status_next    = r_status;
    r_val_next       = r_val;
    r_last_next      = r_last;

    rd_en     = 1'b0;
    rd_addr   = cur[IW-1:0];
    kv_we     = 1'b0;
    kv_addr   = cur[IW-1:0];
    kv_key    = op_key;
    kv_value  = op_value;
    next_we   = 1'b0;
    next_addr = cur[IW-1:0];
    next_data = list_head;
    prev_we   = 1'b0;
    prev_addr = cur[IW-1:0];
    prev_data = NIL;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_cmd_next     = in_cmd;
          op_key_next     = in_key;
          op_value_next   = in_value;
          pend_valid_next = 1'b0;
          n_found_next    = '0;
          r_val_next      = '0;
          r_last_next     = 1'b1;
          unique case (in_cmd) inside
            CMD_ADD: begin
              if (is_slot(free_head)) begin
                rd_en      = 1'b1;
                rd_addr    = free_head[IW-1:0];
                cur_next   = free_head;
                state_next = S_ADD_WR;
              end else begin
                r_status_next = ST_FULL;
                state_next    = S_EMIT;
              end
            end
            CMD_REMOVE, CMD_SEARCH: begin
              if (is_slot(list_head)) begin
                rd_en      = 1'b1;
                rd_addr    = list_head[IW-1:0];
                cur_next   = list_head;
                steps_next = CW'(1);
                state_next = S_WALK;
              end else begin
                r_status_next = ST_NOT_FOUND;
                state_next    = S_EMIT;
              end
            end
            default: begin
              r_status_next = ST_NOT_FOUND;
              state_next    = S_EMIT;
            end
          endcase
        end
      end

      S_ADD_WR: begin
        // new node goes in front of the old head
        kv_we            = 1'b1;
        next_we          = 1'b1;
        next_data        = list_head;
        prev_we          = 1'b1;
        prev_data        = NIL;
        free_head_next   = rd_next;
        list_head_next   = cur;
        entry_count_next = entry_count + CW'(1);
        next_l_next      = list_head;
        if (is_slot(list_head)) begin
          state_next = S_ADD_LINK;
        end else begin
          r_status_next = ST_OK;
          state_next    = S_EMIT;
        end
      end

      S_ADD_LINK: begin
        prev_we       = 1'b1;
        prev_addr     = next_l[IW-1:0];
        prev_data     = cur;
        r_status_next = ST_OK;
        state_next    = S_EMIT;
      end

      S_WALK: begin
        if (op_cmd == CMD_REMOVE) begin
          if (hit) begin
            prev_l_next = rd_prev;
            next_l_next = rd_next;
            state_next  = S_RM_UNLINK;
          end else if (walk_more) begin
            rd_en      = 1'b1;
            rd_addr    = rd_next[IW-1:0];
            cur_next   = rd_next;
            steps_next = steps + CW'(1);
          end else begin
            r_status_next = ST_NOT_FOUND;
            r_val_next    = '0;
            r_last_next   = 1'b1;
            state_next    = S_EMIT;
          end
        end else begin
          n_found_next = n_new;
          if (hit && pend_valid) begin
            // an older match exists, so the held one is not the last
            r_status_next = ST_OK;
            r_val_next    = pend_val;
            r_last_next   = 1'b0;
            pend_val_next = rd_value;
            cur_next      = rd_next;
            state_next    = S_EMIT;
          end else begin
            if (hit) begin
              pend_valid_next = 1'b1;
              pend_val_next   = rd_value;
            end
            if (walk_more) begin
              rd_en      = 1'b1;
              rd_addr    = rd_next[IW-1:0];
              cur_next   = rd_next;
              steps_next = steps + CW'(1);
            end else begin
              r_status_next = (hit || pend_valid) ? ST_OK : ST_NOT_FOUND;
              r_val_next    = hit ? rd_value : (pend_valid ? pend_val : '0);
              r_last_next   = 1'b1;
              state_next    = S_EMIT;
            end
          end
        end
      end

      S_SR_NEXT: begin
        if (is_slot(cur) && steps_more && (n_found < FOUND_W'(MAX_RESULTS))) begin
          rd_en      = 1'b1;
          rd_addr    = cur[IW-1:0];
          steps_next = steps + CW'(1);
          state_next = S_WALK;
        end else begin
          r_status_next = ST_OK;
          r_val_next    = pend_val;
          r_last_next   = 1'b1;
          state_next    = S_EMIT;
        end
      end

      S_RM_UNLINK: begin
        if (is_slot(prev_l)) begin
          next_we   = 1'b1;
          next_addr = prev_l[IW-1:0];
          next_data = next_l;
        end else begin
          list_head_next = next_l;
        end
        if (is_slot(next_l)) begin
          prev_we   = 1'b1;
          prev_addr = next_l[IW-1:0];
          prev_data = prev_l;
        end
        state_next = S_RM_FREE;
      end

      S_RM_FREE: begin
        // freed slot goes on top of the free list
        next_we        = 1'b1;
        next_data      = free_head;
        free_head_next = cur;
        if (entry_count != '0) begin
          entry_count_next = entry_count - CW'(1);
        end
        r_status_next = ST_OK;
        r_val_next    = '0;
        r_last_next   = 1'b1;
        state_next    = S_EMIT;
      end

      S_EMIT: begin
        if (!res_stall) begin
          state_next = r_last ? S_IDLE : S_SR_NEXT;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      free_head   <= '0;
      list_head   <= NIL;
      entry_count <= '0;
      pend_valid  <= 1'b0;
    end else begin
      state       <= state_next;
      free_head   <= free_head_next;
      list_head   <= list_head_next;
      entry_count <= entry_count_next;
      pend_valid  <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_cmd   <= op_cmd_next;
    op_key   <= op_key_next;
    op_value <= op_value_next;
    cur      <= cur_next;
    prev_l   <= prev_l_next;
    next_l   <= next_l_next;
    steps    <= steps_next;
    n_found  <= n_found_next;
    pend_val <= pend_val_next;
    r_status <= r_status_next;
    r_val    <= r_val_next;
    r_last   <= r_last_next;
  end

  always_comb begin
    res.valid  = (state == S_EMIT);
    res.status = r_status;
    res.value  = r_val;
    res.last   = r_last;
    res.count  = COUNT_W'(entry_count);
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_free_empty_full: assert property (@(posedge clk) disable iff (rst)
    !is_slot(free_head) |-> entry_count == CW'(CAPACITY))
    else $error("free list empty while table not full");

  // the count drops in the cycle after the unlink, so only this direction holds
  a_head_empty: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0) |-> !is_slot(list_head))
    else $error("list head and entry count disagree");

  a_multi_only_search: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.last |-> op_cmd == CMD_SEARCH)
    else $error("non-final result outside a search");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input taken again before the transaction finished");

endmodule

// ===== sv/array_linked_multimap_top.sv =====
// Key/value table of CAPACITY pairs kept as a doubly linked list in node memory, newest
// pair at the head, unused slots on a free list. One transaction is worked at a time and
// in_stall stays high until its last result has moved into the output register. A node
// memory read is registered and the list walk reads one node per cycle, pausing while a
// search hands out each found value after the first: add reads the free head, writes
// the node and, on a non-empty list, links the old head back to it; full and unknown
// commands go straight to the result; remove walks to the match, then unlinks and frees
// it; search walks the stored nodes. Each result waits as long as out_stall holds the
// output register. Results of a search come newest first, the final one with last set.
module array_linked_multimap_top #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [alm_pkg::CMD_W-1:0]         cmd,
  input  logic signed [alm_pkg::DATA_W-1:0] key,
  input  logic signed [alm_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [alm_pkg::STAT_W-1:0]        status,
  output logic signed [alm_pkg::DATA_W-1:0] found_value,
  output logic                              last,
  output logic [alm_pkg::COUNT_W-1:0]       count
);
  import alm_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY) + 1;

  res_t                     res;
  res_t                     out_res;
  logic                     res_stall;
  logic                     rd_en;
  logic [IW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rd_key;
  logic signed [DATA_W-1:0] rd_value;
  logic [LW-1:0]            rd_next;
  logic [LW-1:0]            rd_prev;
  logic                     kv_we;
  logic [IW-1:0]            kv_addr;
  logic signed [DATA_W-1:0] kv_key;
  logic signed [DATA_W-1:0] kv_value;
  logic                     next_we;
  logic [IW-1:0]            next_addr;
  logic [LW-1:0]            next_data;
  logic                     prev_we;
  logic [IW-1:0]            prev_addr;
  logic [LW-1:0]            prev_data;

  alm_seq #(.CAPACITY(CAPACITY)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (cmd),
    .in_key    (key),
    .in_value  (value),
    .res       (res),
    .res_stall (res_stall),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_value  (rd_value),
    .rd_next   (rd_next),
    .rd_prev   (rd_prev),
    .kv_we     (kv_we),
    .kv_addr   (kv_addr),
    .kv_key    (kv_key),
    .kv_value  (kv_value),
    .next_we   (next_we),
    .next_addr (next_addr),
    .next_data (next_data),
    .prev_we   (prev_we),
    .prev_addr (prev_addr),
    .prev_data (prev_data)
  );

  alm_nodes #(.CAPACITY(CAPACITY)) u_nodes (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_key    (rd_key),
    .rd_value  (rd_value),
    .rd_next   (rd_next),
    .rd_prev   (rd_prev),
    .kv_we     (kv_we),
    .kv_addr   (kv_addr),
    .kv_key    (kv_key),
    .kv_value  (kv_value),
    .next_we   (next_we),
    .next_addr (next_addr),
    .next_data (next_data),
    .prev_we   (prev_we),
    .prev_addr (prev_addr),
    .prev_data (prev_data)
  );

  // output register: a finished result waits here while the sequencer moves on
  assign res_stall = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && !res_stall) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && !res_stall) begin
      out_res <= res;
    end
  end

  assign status      = out_res.status;
  assign found_value = out_res.value;
  assign last        = out_res.last;
  assign count       = out_res.count;

endmodule
